### src/hvki_pkg.sv
package hvki_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int FRAC_BITS = 16;
	localparam int AW        = $clog2(MAX_KEYS);
	localparam int CW        = 7;
	localparam int UW        = FRAC_BITS + 1;
	localparam int KW        = 32;
	localparam int TW        = KW + 6;
	localparam int WW        = FRAC_BITS + 4;
	localparam int PW        = 64;

	typedef enum logic {
		REG_SPLINE_ENABLE = 1'b0,
		REG_KEY_COUNT     = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic spline;
		logic few;
		logic one;
	} ctrl_t;

	function automatic logic [KW-1:0] sat32(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = PW'(signed'({1'b0, {(KW-1){1'b1}}}));
		lo = -hi - PW'(1);
		if (v > hi) return hi[KW-1:0];
		if (v < lo) return lo[KW-1:0];
		return v[KW-1:0];
	endfunction

endpackage

### src/hvki_keymem.sv
module hvki_keymem
	import hvki_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [3*KW-1:0]   wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [3*KW-1:0]   rdata
);

	logic [3*KW-1:0] mem_q [MAX_KEYS];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[raddr];
	end

endmodule

### src/hermite_vector_key_interp.sv
// accepted evaluate words pass the registered stages into result words;
// one word per cycle unless the output stalls, loads and evaluates alike;
// the four key reads go to four copies of the key memory, one port each
// reset: arst_n clears valid bits and registers (spline on, no keys);
// the key memory is not cleared and needs no clearing pass
module hermite_vector_key_interp
	import hvki_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// apb configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// key_index, key_x, key_y, key_z, fraction, zero fill
	input  logic [119:0] s_tdata,
	// kind
	input  logic         s_tuser,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y, pos_z, tan_x, tan_y, tan_z
	output logic [191:0] m_tdata
);

	localparam logic [UW-1:0] ONE  = UW'(1) << FRAC_BITS;
	localparam logic [UW:0]   HALF = (UW+1)'(1) << (FRAC_BITS-1);

	logic          spline_q;
	logic [CW-1:0] count_q;
	logic          en;
	logic          acc;

	assign pready = 1'b1;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign acc = s_tvalid && s_tready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spline_q <= 1'b1;
			count_q  <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_index_t'(paddr[2]))
				REG_SPLINE_ENABLE: spline_q <= pwdata[0];
				REG_KEY_COUNT:     count_q  <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index_t'(paddr[2]))
			REG_SPLINE_ENABLE: prdata = {31'd0, spline_q};
			REG_KEY_COUNT:     prdata = {{(32-CW){1'b0}}, count_q};
			default:           prdata = '0;
		endcase
	end

	// input fields
	logic [AW-1:0] in_idx;
	logic [UW-1:0] in_frac;
	assign in_idx  = s_tdata[5:0];
	assign in_frac = s_tdata[118:102];

	// segment select
	logic [CW-1:0] n;
	logic [CW-1:0] seg;
	logic [AW-1:0] seg_a;
	ctrl_t         c0;
	always_comb begin
		n = (count_q > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : count_q;
		if (n < CW'(2)) seg = '0;
		else if (CW'(in_idx) > n - CW'(2)) seg = n - CW'(2);
		else seg = CW'(in_idx);
		seg_a     = seg[AW-1:0];
		c0.valid  = acc && s_tuser;
		c0.first  = (seg == '0);
		c0.last   = (seg + CW'(2) >= n);
		c0.spline = spline_q && (n >= CW'(3));
		c0.few    = (n < CW'(2));
		c0.one    = (n == CW'(1));
	end

	logic [3*KW-1:0] rd [4];
	logic [AW-1:0]   ra [4];
	assign ra[0] = seg_a - AW'(1);
	assign ra[1] = seg_a;
	assign ra[2] = seg_a + AW'(1);
	assign ra[3] = seg_a + AW'(2);

	for (genvar g = 0; g < 4; g++) begin : g_mem
		hvki_keymem u_mem (
			.clk   (clk),
			.we    (acc && !s_tuser),
			.waddr (in_idx),
			.wdata (s_tdata[101:6]),
			.re    (acc && s_tuser),
			.raddr (ra[g]),
			.rdata (rd[g])
		);
	end

	// stage 1: keys arrive
	ctrl_t         ctl_s1;
	logic [UW-1:0] u_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s1 <= '0;
		else if (en) ctl_s1 <= c0;
	end
	always_ff @(posedge clk) begin
		if (en) u_s1 <= (in_frac > ONE) ? ONE : in_frac;
	end

	logic signed [KW:0] k [4][3];
	always_comb begin
		for (int j = 0; j < 4; j++)
			for (int a = 0; a < 3; a++)
				k[j][a] = (KW+1)'(signed'(rd[j][a*KW +: KW]));
	end

	// stage 2: tangents and square
	ctrl_t              ctl_s2;
	logic [UW-1:0]      u_s2;
	logic [UW-1:0]      fsq_s2;
	logic signed [TW-1:0] m0_s2 [3];
	logic signed [TW-1:0] m1_s2 [3];
	logic signed [KW:0]   p0_s2 [3];
	logic signed [KW:0]   p1_s2 [3];
	logic [2*UW-1:0]      sq;
	assign sq = u_s1 * u_s1 + (2*UW)'(HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s2 <= '0;
		else if (en) ctl_s2 <= ctl_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			u_s2   <= u_s1;
			fsq_s2 <= sq[FRAC_BITS +: UW];
			for (int a = 0; a < 3; a++) begin
				p0_s2[a] <= k[1][a];
				p1_s2[a] <= k[2][a];
				if (ctl_s1.first)
					m0_s2[a] <= TW'(6) * TW'(k[2][a] - k[1][a]) - TW'(k[3][a] - k[1][a]);
				else
					m0_s2[a] <= TW'(2) * TW'(k[2][a] - k[0][a]);
				if (ctl_s1.last)
					m1_s2[a] <= TW'(6) * TW'(k[2][a] - k[1][a]) - TW'(k[2][a] - k[0][a]);
				else
					m1_s2[a] <= TW'(2) * TW'(k[3][a] - k[1][a]);
			end
		end
	end

	// stage 3: cube
	ctrl_t         ctl_s3;
	logic [UW-1:0] u_s3, fsq_s3, fcu_s3;
	logic signed [TW-1:0] m0_s3 [3];
	logic signed [TW-1:0] m1_s3 [3];
	logic signed [KW:0]   p0_s3 [3];
	logic signed [KW:0]   p1_s3 [3];
	logic [2*UW-1:0]      cu;
	assign cu = fsq_s2 * u_s2 + (2*UW)'(HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s3 <= '0;
		else if (en) ctl_s3 <= ctl_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			u_s3   <= u_s2;
			fsq_s3 <= fsq_s2;
			fcu_s3 <= cu[FRAC_BITS +: UW];
			m0_s3  <= m0_s2;
			m1_s3  <= m1_s2;
			p0_s3  <= p0_s2;
			p1_s3  <= p1_s2;
		end
	end

	// stage 4: basis weights
	ctrl_t ctl_s4;
	logic signed [WW-1:0] h00_s4, h10_s4, h01_s4, h11_s4;
	logic signed [WW-1:0] da_s4, db_s4, dc_s4, dd_s4;
	logic [UW-1:0] u_s4;
	logic signed [TW-1:0] m0_s4 [3];
	logic signed [TW-1:0] m1_s4 [3];
	logic signed [KW:0]   p0_s4 [3];
	logic signed [KW:0]   p1_s4 [3];
	logic signed [WW-1:0] wu, wsq, wcu, wone;
	assign wu   = WW'(signed'({1'b0, u_s3}));
	assign wsq  = WW'(signed'({1'b0, fsq_s3}));
	assign wcu  = WW'(signed'({1'b0, fcu_s3}));
	assign wone = WW'(signed'({1'b0, ONE}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s4 <= '0;
		else if (en) ctl_s4 <= ctl_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			h00_s4 <= WW'(2)*wcu - WW'(3)*wsq + wone;
			h10_s4 <= wcu - WW'(2)*wsq + wu;
			h01_s4 <= WW'(3)*wsq - WW'(2)*wcu;
			h11_s4 <= wcu - wsq;
			da_s4  <= WW'(6)*wsq - WW'(6)*wu;
			db_s4  <= WW'(3)*wsq - WW'(4)*wu + wone;
			dc_s4  <= WW'(6)*wu - WW'(6)*wsq;
			dd_s4  <= WW'(3)*wsq - WW'(2)*wu;
			u_s4   <= u_s3;
			m0_s4  <= m0_s3;
			m1_s4  <= m1_s3;
			p0_s4  <= p0_s3;
			p1_s4  <= p1_s3;
		end
	end

	// stage 5: products
	ctrl_t ctl_s5;
	logic signed [PW-1:0] ph00_s5 [3], ph01_s5 [3], ph10_s5 [3], ph11_s5 [3];
	logic signed [PW-1:0] pda_s5 [3], pdc_s5 [3], pdb_s5 [3], pdd_s5 [3];
	logic signed [PW-1:0] lin_s5 [3];
	logic signed [KW:0]   p0_s5 [3];
	logic signed [KW:0]   d_s5 [3];
	logic signed [PW-1:0] su;
	assign su = PW'(signed'({1'b0, u_s4}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s5 <= '0;
		else if (en) ctl_s5 <= ctl_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				ph00_s5[a] <= PW'(h00_s4) * PW'(p0_s4[a]);
				ph01_s5[a] <= PW'(h01_s4) * PW'(p1_s4[a]);
				ph10_s5[a] <= PW'(h10_s4) * PW'(m0_s4[a]);
				ph11_s5[a] <= PW'(h11_s4) * PW'(m1_s4[a]);
				pda_s5[a]  <= PW'(da_s4) * PW'(p0_s4[a]);
				pdc_s5[a]  <= PW'(dc_s4) * PW'(p1_s4[a]);
				pdb_s5[a]  <= PW'(db_s4) * PW'(m0_s4[a]);
				pdd_s5[a]  <= PW'(dd_s4) * PW'(m1_s4[a]);
				lin_s5[a]  <= PW'(p1_s4[a] - p0_s4[a]) * su;
				p0_s5[a]   <= p0_s4[a];
				d_s5[a]    <= p1_s4[a] - p0_s4[a];
			end
		end
	end

	// stage 6: sums, rounding, saturation into the output register
	logic [KW-1:0] pos_r [3];
	logic [KW-1:0] tan_r [3];
	always_comb begin
		logic signed [PW-1:0] ps, ds, ls;
		for (int a = 0; a < 3; a++) begin
			ps = PW'(4) * (ph00_s5[a] + ph01_s5[a]) + ph10_s5[a] + ph11_s5[a]
			     + (PW'(1) <<< (FRAC_BITS+1));
			ds = PW'(4) * (pda_s5[a] + pdc_s5[a]) + pdb_s5[a] + pdd_s5[a]
			     + (PW'(1) <<< (FRAC_BITS+1));
			ls = (PW'(p0_s5[a]) <<< FRAC_BITS) + lin_s5[a] + (PW'(1) <<< (FRAC_BITS-1));
			if (ctl_s5.few) begin
				pos_r[a] = ctl_s5.one ? p0_s5[a][KW-1:0] : '0;
				tan_r[a] = (a == 1) ? KW'(ONE) : '0;
			end else if (ctl_s5.spline) begin
				pos_r[a] = sat32(ps >>> (FRAC_BITS+2));
				tan_r[a] = sat32(ds >>> (FRAC_BITS+2));
			end else begin
				pos_r[a] = sat32(ls >>> FRAC_BITS);
				tan_r[a] = sat32(PW'(d_s5[a]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= ctl_s5.valid;
	end
	always_ff @(posedge clk) begin
		if (en) m_tdata <= {tan_r[2], tan_r[1], tan_r[0], pos_r[2], pos_r[1], pos_r[0]};
	end

endmodule

### src/hvki_checker.sv
module hvki_checker
	import hvki_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         pready,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [191:0] m_tdata
);

	// a stalled result word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result word changed while stalled");

	// input side only waits on a full, stalled output register
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output state");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("apb pready low");

endmodule

bind hermite_vector_key_interp hvki_checker u_hvki_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
